/* hw/rtl/lbfp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbfp_pkg
// Shared constants and types for the LSB-first bit field packer.
// ----------------------------------------------------------------------------
package lbfp_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int CAP_BITS     = BUFFER_BYTES * 8;
    localparam int POS_W        = $clog2(CAP_BITS + 1);
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int FIELD_W      = 32;
    localparam int COUNT_W      = 6;
    localparam int STATUS_W     = 2;
    localparam int SPAN_BYTES   = 5;
    localparam int SPAN_W       = SPAN_BYTES * 8;
    localparam int NB_W         = $clog2(SPAN_BYTES + 1);
    localparam int SLOT_W       = $clog2(SPAN_BYTES);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_UNDERRUN = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic wr_step;
        logic rd_step;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_read_now;
        logic no_bytes_now;
        logic last_byte;
    } t_stat;

endpackage
`default_nettype wire

/* hw/rtl/lbfp_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbfp_in_if
// Request channel: opcode, field value and bit count with valid/ready.
// ----------------------------------------------------------------------------
interface lbfp_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [lbfp_pkg::FIELD_W-1:0]  value;
    logic [lbfp_pkg::COUNT_W-1:0]  bit_count;

    modport source (output valid, output opcode, output value, output bit_count, input ready);
    modport sink   (input valid, input opcode, input value, input bit_count, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lbfp_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbfp_out_if
// Result channel: read value and status with valid/ready.
// ----------------------------------------------------------------------------
interface lbfp_out_if;
    logic                          valid;
    logic                          ready;
    logic [lbfp_pkg::FIELD_W-1:0]  read_value;
    logic [lbfp_pkg::STATUS_W-1:0] status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lbfp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbfp_ctrl
// Sequencer: steps the datapath through one byte access per cycle.
// ----------------------------------------------------------------------------
module lbfp_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    input  lbfp_pkg::t_stat i_stat,
    output lbfp_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WRITE  = 5'b00010,
        S_READ   = 5'b00100,
        S_WAIT   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_cmd          = '0;
        o_cmd.load     = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.no_bytes_now) begin
                        n_state = S_FINISH;
                    end else if (i_stat.op_read_now) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.wr_step = 1'b1;
                if (i_stat.last_byte) begin
                    n_state = S_FINISH;
                end
            end
            S_READ: begin
                o_cmd.rd_step = 1'b1;
                if (i_stat.last_byte) begin
                    n_state = S_WAIT;
                end
            end
            // last read byte lands in the assembly register
            S_WAIT: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/lbfp_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbfp_dp
// Datapath: bit positions, byte memory, write shifter and read assembly.
// ----------------------------------------------------------------------------
module lbfp_dp (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_opcode,
    input  wire  [lbfp_pkg::FIELD_W-1:0]    i_value,
    input  wire  [lbfp_pkg::COUNT_W-1:0]    i_bit_count,
    input  lbfp_pkg::t_cmd                  i_cmd,
    output lbfp_pkg::t_stat                 o_stat,
    output logic [lbfp_pkg::FIELD_W-1:0]    o_read_value,
    output logic [lbfp_pkg::STATUS_W-1:0]   o_status
);

    function automatic logic [lbfp_pkg::FIELD_W-1:0] f_mask(
        input logic [lbfp_pkg::COUNT_W-1:0] n
    );
        logic [lbfp_pkg::FIELD_W:0] m;
        m = ((lbfp_pkg::FIELD_W+1)'(1) << n) - (lbfp_pkg::FIELD_W+1)'(1);
        return m[lbfp_pkg::FIELD_W-1:0];
    endfunction

    logic [7:0]                       r_mem [lbfp_pkg::BUFFER_BYTES];

    logic [lbfp_pkg::POS_W-1:0]       r_wpos, r_rpos;
    logic [7:0]                       r_tail;
    logic                             r_op;
    logic [lbfp_pkg::COUNT_W-1:0]     r_n;
    logic [2:0]                       r_sh;
    lbfp_pkg::t_status                r_stat;
    logic [lbfp_pkg::SPAN_W-1:0]      r_wbuf;
    logic [lbfp_pkg::ADDR_W-1:0]      r_addr;
    logic [lbfp_pkg::NB_W-1:0]        r_nb;
    logic [lbfp_pkg::SLOT_W-1:0]      r_k, r_slot;
    logic                             r_pend;
    logic [7:0]                       r_rdata;
    logic [lbfp_pkg::SPAN_W-1:0]      r_acc;
    logic [lbfp_pkg::FIELD_W-1:0]     r_read_value;
    lbfp_pkg::t_status                r_out_status;

    logic                             is_read;
    logic [lbfp_pkg::COUNT_W-1:0]     cnt_sat, n_cnt;
    logic [lbfp_pkg::POS_W-1:0]       room, avail, lim;
    logic                             short;
    logic [2:0]                       sh;
    logic [6:0]                       span;
    logic [lbfp_pkg::NB_W-1:0]        nb;
    logic [lbfp_pkg::FIELD_W-1:0]     masked;
    logic [lbfp_pkg::SPAN_W-1:0]      wbuf, acc_sh;

    always_comb begin
        is_read = (i_opcode == lbfp_pkg::OP_READ);
        cnt_sat = (i_bit_count > lbfp_pkg::COUNT_W'(lbfp_pkg::FIELD_W))
                ? lbfp_pkg::COUNT_W'(lbfp_pkg::FIELD_W) : i_bit_count;
        room    = lbfp_pkg::POS_W'(lbfp_pkg::CAP_BITS) - r_wpos;
        avail   = r_wpos - r_rpos;
        lim     = is_read ? avail : room;
        short   = 32'(cnt_sat) > 32'(lim);
        n_cnt   = short ? lbfp_pkg::COUNT_W'(lim) : cnt_sat;
        sh      = is_read ? r_rpos[2:0] : r_wpos[2:0];
        span    = 7'(sh) + 7'(n_cnt) + 7'd7;
        nb      = (n_cnt == '0) ? '0 : lbfp_pkg::NB_W'(span >> 3);
        masked  = i_value & f_mask(n_cnt);
        // partial byte keeps its earlier bits; a fresh byte starts clear
        wbuf    = (lbfp_pkg::SPAN_W'(masked) << sh)
                | ((sh == 3'd0) ? '0 : lbfp_pkg::SPAN_W'(r_tail));
        acc_sh  = r_acc >> r_sh;
    end

    assign o_stat.op_read_now  = is_read;
    assign o_stat.no_bytes_now = (nb == '0);
    assign o_stat.last_byte    = (r_nb == lbfp_pkg::NB_W'(1));
    assign o_read_value        = r_read_value;
    assign o_status            = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_rpos <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd_step;
            if (i_cmd.load) begin
                if (is_read) begin
                    r_rpos <= r_rpos + lbfp_pkg::POS_W'(n_cnt);
                end else begin
                    r_wpos <= r_wpos + lbfp_pkg::POS_W'(n_cnt);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_n    <= n_cnt;
            r_sh   <= sh;
            r_nb   <= nb;
            r_k    <= '0;
            r_wbuf <= wbuf;
            r_addr <= is_read ? r_rpos[lbfp_pkg::ADDR_W+2:3] : r_wpos[lbfp_pkg::ADDR_W+2:3];
            if (short) begin
                r_stat <= is_read ? lbfp_pkg::ST_UNDERRUN : lbfp_pkg::ST_OVERFLOW;
            end else begin
                r_stat <= lbfp_pkg::ST_OK;
            end
        end
        if (i_cmd.wr_step) begin
            r_mem[r_addr] <= r_wbuf[7:0];
            r_tail        <= r_wbuf[7:0];
            r_wbuf        <= r_wbuf >> 8;
            r_addr        <= r_addr + lbfp_pkg::ADDR_W'(1);
            r_nb          <= r_nb - lbfp_pkg::NB_W'(1);
        end
        if (i_cmd.rd_step) begin
            r_rdata <= r_mem[r_addr];
            r_slot  <= r_k;
            r_k     <= r_k + lbfp_pkg::SLOT_W'(1);
            r_addr  <= r_addr + lbfp_pkg::ADDR_W'(1);
            r_nb    <= r_nb - lbfp_pkg::NB_W'(1);
        end
        if (r_pend) begin
            r_acc[8*r_slot +: 8] <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_stat;
            if (r_op == lbfp_pkg::OP_READ) begin
                r_read_value <= acc_sh[lbfp_pkg::FIELD_W-1:0] & f_mask(r_n);
            end else begin
                r_read_value <= '0;
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/lsb_first_bit_field_packer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_first_bit_field_packer
// Appends variable-width fields LSB first to a byte memory and reads them back.
// ----------------------------------------------------------------------------
// One request at a time; each returns exactly one result. The byte memory is
// single ported and moves one byte per cycle, so a request walks the B bytes
// that it touches (0..5, from bit offset plus field width) one by one: in
// S_WRITE for an append, in S_READ then S_WAIT for a read, then S_FINISH.
// A zero-width request goes straight to S_FINISH. The next request is taken
// while the previous result still waits on the output. No clearing pass is
// needed after reset: reads only ever touch bits below the write position.
module lsb_first_bit_field_packer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lbfp_in_if.sink     i_req,
    lbfp_out_if.source  o_rsp
);

    lbfp_pkg::t_cmd  cmd;
    lbfp_pkg::t_stat stat;

    lbfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lbfp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (i_req.opcode),
        .i_value      (i_req.value),
        .i_bit_count  (i_req.bit_count),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_read_value (o_rsp.read_value),
        .o_status     (o_rsp.status)
    );

    // a request is never followed by another in the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted back to back");

    // overflowing appends always report a zero read value
    a_overflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == lbfp_pkg::ST_OVERFLOW)) |-> (o_rsp.read_value == '0))
        else $error("overflow result carries nonzero read value");

    // result is loaded only on the way back to idle
    a_load_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> i_req.ready)
        else $error("result load did not return to idle");

    // memory steps never overlap a new request
    a_no_step_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> !(cmd.wr_step || cmd.rd_step || cmd.out_load))
        else $error("request taken while datapath busy");

endmodule
`default_nettype wire

/* dv/tb_lsb_first_bit_field_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_field_packer
// Self-checking bench for the LSB-first field packer. A queue of append and
// read requests (directed corner cases, then random traffic that fills the
// byte store past its end and drains it) feeds a bursty driver. A shadow copy
// of the store and both bit positions predicts each result, and a monitor
// with its own stall pattern checks every response in order.
// ----------------------------------------------------------------------------
module tb_lsb_first_bit_field_packer;

    localparam int RANDOM_REQUESTS = 1075;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct {
        logic                         opcode;
        logic [lbfp_pkg::FIELD_W-1:0] value;
        logic [lbfp_pkg::COUNT_W-1:0] bit_count;
    } t_field_req;

    typedef struct {
        logic [lbfp_pkg::FIELD_W-1:0] read_value;
        lbfp_pkg::t_status            status;
    } t_field_rsp;

    logic clk;
    logic rst_n;

    lbfp_in_if  req_if ();
    lbfp_out_if rsp_if ();

    lsb_first_bit_field_packer DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow of the block state
    logic [7:0]  shadow_bytes [lbfp_pkg::BUFFER_BYTES];
    int unsigned shadow_wr_pos = 0;
    int unsigned shadow_rd_pos = 0;

    t_field_req  queued_reqs  [$];
    t_field_rsp  awaited_rsps [$];

    // positions as the request list will leave them, used to steer stimulus
    int unsigned plan_wr_pos = 0;
    int unsigned plan_rd_pos = 0;

    int unsigned n_total    = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned n_errors   = 0;
    int unsigned n_writes   = 0;
    int unsigned n_reads    = 0;
    int unsigned n_overflow = 0;
    int unsigned n_underrun = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic t_field_rsp pack_field(t_field_req req);
        t_field_rsp  rsp;
        int unsigned width;
        int unsigned byte_idx;
        int unsigned bit_idx;
        int unsigned i;
        rsp.read_value = '0;
        rsp.status     = lbfp_pkg::ST_OK;
        width = (req.bit_count > lbfp_pkg::FIELD_W) ? lbfp_pkg::FIELD_W : req.bit_count;
        for (i = 0; i < width; i++) begin
            if (req.opcode == lbfp_pkg::OP_WRITE) begin
                if (shadow_wr_pos < lbfp_pkg::CAP_BITS) begin
                    byte_idx = shadow_wr_pos / 8;
                    bit_idx  = shadow_wr_pos % 8;
                    // first bit of a byte clears it
                    if (bit_idx == 0)
                        shadow_bytes[byte_idx] = '0;
                    shadow_bytes[byte_idx][bit_idx] = req.value[i];
                    shadow_wr_pos++;
                end else begin
                    rsp.status = lbfp_pkg::ST_OVERFLOW;
                end
            end else begin
                if (shadow_rd_pos < shadow_wr_pos) begin
                    byte_idx = shadow_rd_pos / 8;
                    bit_idx  = shadow_rd_pos % 8;
                    rsp.read_value[i] = shadow_bytes[byte_idx][bit_idx];
                    shadow_rd_pos++;
                end else begin
                    rsp.status = lbfp_pkg::ST_UNDERRUN;
                end
            end
        end
        return rsp;
    endfunction

    task automatic queue_request(input logic op,
                                 input logic [lbfp_pkg::FIELD_W-1:0] value,
                                 input logic [lbfp_pkg::COUNT_W-1:0] count);
        t_field_req  req;
        int unsigned width;
        req.opcode    = op;
        req.value     = value;
        req.bit_count = count;
        width = (count > lbfp_pkg::FIELD_W) ? lbfp_pkg::FIELD_W : count;
        if (op == lbfp_pkg::OP_WRITE)
            plan_wr_pos = (plan_wr_pos + width > lbfp_pkg::CAP_BITS) ? lbfp_pkg::CAP_BITS
                                                                     : plan_wr_pos + width;
        else
            plan_rd_pos = (plan_rd_pos + width > plan_wr_pos) ? plan_wr_pos
                                                              : plan_rd_pos + width;
        queued_reqs.push_back(req);
    endtask

    function automatic logic [lbfp_pkg::COUNT_W-1:0] random_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return lbfp_pkg::COUNT_W'($urandom_range(33, 63));
            2:       return lbfp_pkg::COUNT_W'(lbfp_pkg::FIELD_W);
            default: return lbfp_pkg::COUNT_W'($urandom_range(1, 31));
        endcase
    endfunction

    function automatic logic [lbfp_pkg::FIELD_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // driver: bursts of back-to-back requests separated by random gaps
    int unsigned burst_left;
    int unsigned gap_left;
    t_field_req  taken_req;
    t_field_req  next_req;
    t_field_rsp  predicted;

    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid     <= 1'b0;
            req_if.opcode    <= lbfp_pkg::OP_WRITE;
            req_if.value     <= '0;
            req_if.bit_count <= '0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                taken_req.opcode    = req_if.opcode;
                taken_req.value     = req_if.value;
                taken_req.bit_count = req_if.bit_count;
                predicted = pack_field(taken_req);
                awaited_rsps.push_back(predicted);
                if (taken_req.opcode == lbfp_pkg::OP_WRITE)
                    n_writes++;
                else
                    n_reads++;
                if (predicted.status == lbfp_pkg::ST_OVERFLOW)
                    n_overflow++;
                if (predicted.status == lbfp_pkg::ST_UNDERRUN)
                    n_underrun++;
                n_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (queued_reqs.size() > 0) begin
                    next_req = queued_reqs.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.opcode    <= next_req.opcode;
                    req_if.value     <= next_req.value;
                    req_if.bit_count <= next_req.bit_count;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: ready follows a rotating pattern, reloaded every so often
    logic [15:0] ready_pattern;
    int unsigned pattern_left;
    t_field_rsp  oldest;

    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            ready_pattern = '1;
            pattern_left  = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (awaited_rsps.size() == 0) begin
                    $display("%0t: unexpected result: expected none, %s %h status %0d",
                             $time, "actual read_value", rsp_if.read_value, rsp_if.status);
                    n_errors++;
                end else begin
                    oldest = awaited_rsps.pop_front();
                    if (rsp_if.read_value !== oldest.read_value) begin
                        $display("%0t: read_value mismatch: expected %h actual %h",
                                 $time, oldest.read_value, rsp_if.read_value);
                        n_errors++;
                    end
                    if (rsp_if.status !== oldest.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, oldest.status, rsp_if.status);
                        n_errors++;
                    end
                    n_checked++;
                end
            end
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;
                    2:       ready_pattern = 16'($urandom_range(0, 65535)
                                                 & $urandom_range(0, 65535))
                                             | 16'h0001;
                    default: ready_pattern = 16'hFF00;
                endcase
                pattern_left = $urandom_range(40, 200);
            end
            pattern_left--;
            rsp_if.ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // watchdog on cycles where neither channel moves
    int unsigned idle_cycles;

    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles = 0;
        end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("%0t: nothing accepted for %0d cycles, %0d of %0d requests taken",
                         $time, IDLE_LIMIT, n_accepted, n_total);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int unsigned phase_left;
        int unsigned write_pct;
        int unsigned k;

        req_if.valid     = 1'b0;
        req_if.opcode    = lbfp_pkg::OP_WRITE;
        req_if.value     = '0;
        req_if.bit_count = '0;
        rsp_if.ready     = 1'b0;
        rst_n            = 1'b0;
        for (k = 0; k < lbfp_pkg::BUFFER_BYTES; k++)
            shadow_bytes[k] = '0;

        // read on an empty store, zero-width requests
        queue_request(lbfp_pkg::OP_READ,  32'hFFFF_FFFF, 6'd0);
        queue_request(lbfp_pkg::OP_READ,  32'h0000_0000, 6'd5);
        queue_request(lbfp_pkg::OP_WRITE, 32'hFFFF_FFFF, 6'd0);
        // odd widths to walk across byte boundaries, upper value bits masked
        queue_request(lbfp_pkg::OP_WRITE, 32'h0000_0001, 6'd1);
        queue_request(lbfp_pkg::OP_WRITE, 32'hFFFF_FFFF, 6'd7);
        queue_request(lbfp_pkg::OP_WRITE, 32'hFFFF_FFFF, 6'd32);
        queue_request(lbfp_pkg::OP_WRITE, 32'h0000_0000, 6'd32);
        // oversized counts saturate to a full field
        queue_request(lbfp_pkg::OP_WRITE, 32'hA5A5_A5A5, 6'd63);
        queue_request(lbfp_pkg::OP_WRITE, 32'h5A5A_5A5A, 6'd33);
        queue_request(lbfp_pkg::OP_WRITE, 32'hFFFF_FFFE, 6'd1);
        queue_request(lbfp_pkg::OP_READ,  32'hFFFF_FFFF, 6'd1);
        queue_request(lbfp_pkg::OP_READ,  32'h0000_0000, 6'd7);
        queue_request(lbfp_pkg::OP_READ,  32'h1234_5678, 6'd32);
        queue_request(lbfp_pkg::OP_READ,  32'h0000_0000, 6'd32);
        queue_request(lbfp_pkg::OP_READ,  32'h0000_0000, 6'd40);
        queue_request(lbfp_pkg::OP_READ,  32'h0000_0000, 6'd32);
        // one bit left, then reads run past the written bits
        queue_request(lbfp_pkg::OP_READ,  32'h0000_0000, 6'd63);
        queue_request(lbfp_pkg::OP_READ,  32'h0000_0000, 6'd32);
        queue_request(lbfp_pkg::OP_WRITE, 32'h8000_0001, 6'd32);
        queue_request(lbfp_pkg::OP_WRITE, 32'hFFFF_FFFF, 6'd3);
        queue_request(lbfp_pkg::OP_READ,  32'h0000_0000, 6'd16);
        queue_request(lbfp_pkg::OP_READ,  32'h0000_0000, 6'd16);
        queue_request(lbfp_pkg::OP_READ,  32'h0000_0000, 6'd3);

        // random traffic in phases that lean toward appends or toward reads
        phase_left = 0;
        write_pct  = 55;
        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       write_pct = 30;
                    1:       write_pct = 55;
                    default: write_pct = 80;
                endcase
                phase_left = $urandom_range(30, 80);
            end
            phase_left--;
            queue_request(($urandom_range(1, 100) <= write_pct) ? lbfp_pkg::OP_WRITE
                                                                : lbfp_pkg::OP_READ,
                          random_value(), random_count());
        end

        // make sure the store fills, overflows, and is drained past its end
        while (plan_wr_pos < lbfp_pkg::CAP_BITS)
            queue_request(lbfp_pkg::OP_WRITE, random_value(), 6'd32);
        repeat (6) queue_request(lbfp_pkg::OP_WRITE, random_value(), random_count());
        queue_request(lbfp_pkg::OP_WRITE, 32'hFFFF_FFFF, 6'd0);
        while (plan_rd_pos < plan_wr_pos)
            queue_request(lbfp_pkg::OP_READ, random_value(), 6'd32);
        queue_request(lbfp_pkg::OP_READ, 32'h0000_0000, 6'd32);
        queue_request(lbfp_pkg::OP_READ, 32'h0000_0000, 6'd0);
        n_total = queued_reqs.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_total || awaited_rsps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d of %0d requests: %0d appends, %0d reads.",
                 n_checked, n_total, n_writes, n_reads);
        $display("Saw %0d overflow and %0d underrun results; write position ended at %0d bits.",
                 n_overflow, n_underrun, shadow_wr_pos);
        if (n_errors == 0 && awaited_rsps.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lbfp_pkg.sv
hw/rtl/lbfp_in_if.sv
hw/rtl/lbfp_out_if.sv
hw/rtl/lbfp_ctrl.sv
hw/rtl/lbfp_dp.sv
hw/rtl/lsb_first_bit_field_packer.sv
dv/tb_lsb_first_bit_field_packer.sv
